// ===== rtl/rdoc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdoc_pkg
// shared types and constants of the range digit occurrence counter
// ----------------------------------------------------------------------------
package rdoc_pkg;

  localparam int DIGITS = 8;
  localparam int BOUND_W = 27;
  localparam int OCC_W = 27;
  localparam int DIGIT_W = 4;
  localparam int POS_W = $clog2(DIGITS + 1);
  localparam int BCD_W = 4 * DIGITS;
  localparam int ACC_W = 64;
  localparam logic [DIGIT_W-1:0] LAST_DIGIT = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_HI,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic count_hi;
    logic start_digit;
    logic next_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic pos_done;
    logic last_digit;
  } dp_stat_t;

  function automatic logic [ACC_W-1:0] pow10(input logic [POS_W-1:0] e);
    logic [ACC_W-1:0] p;
    p = 1;
    for (int k = 0; k < DIGITS; k++) begin
      if (k < int'(e)) p = p * 10;
    end
    return p;
  endfunction

endpackage

// ===== rtl/rdoc_datapath.sv =====
// ----------------------------------------------------------------------------
// rdoc_datapath
// bound conversion to bcd, per-position digit count for upper and lower bound
// ----------------------------------------------------------------------------
module rdoc_datapath import rdoc_pkg::*; (
  input  logic               clk,
  input  logic [BOUND_W-1:0] bound_one,
  input  logic [BOUND_W-1:0] bound_two,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic [DIGIT_W-1:0] digit,
  output logic [OCC_W-1:0]   occurrences
);

  localparam logic [BOUND_W-1:0] MAXV = BOUND_W'(pow10(POS_W'(DIGITS)) - 1);
  localparam logic [BOUND_W-1:0] RECIP10 = 27'd107374183;

  logic [BOUND_W-1:0] hi_bin, lo_bin;
  logic [BOUND_W-1:0] hi_val, lo_val;
  logic [BCD_W-1:0]   hi_bcd, lo_bcd;
  logic [POS_W-1:0]   conv_cnt;
  logic [POS_W-1:0]   pos;
  logic [DIGIT_W-1:0] dsel;
  logic [POS_W-1:0]   hi_len, lo_len;
  logic [OCC_W-1:0]   acc;
  logic [BOUND_W-1:0] hi_pre, lo_pre;
  logic [BOUND_W-1:0] hi_rem, lo_rem;
  logic [BOUND_W-1:0] a, b;

  always_comb begin
    a = (bound_one == '0) ? BOUND_W'(1) : (bound_one > MAXV ? MAXV : bound_one);
    b = (bound_two == '0) ? BOUND_W'(1) : (bound_two > MAXV ? MAXV : bound_two);
  end

  // one digit per cycle by divide by ten via reciprocal
  logic [BOUND_W-1:0]   hq, lq;
  logic [3:0]           hr, lr;
  logic [2*BOUND_W-1:0] hm, lm;
  always_comb begin
    hm = (2*BOUND_W)'(hi_bin) * (2*BOUND_W)'(RECIP10);
    lm = (2*BOUND_W)'(lo_bin) * (2*BOUND_W)'(RECIP10);
    hq = BOUND_W'(hm >> 30);
    lq = BOUND_W'(lm >> 30);
    hr = 4'(hi_bin - BOUND_W'(hq * BOUND_W'(10)));
    lr = 4'(lo_bin - BOUND_W'(lq * BOUND_W'(10)));
  end

  // weight of one decimal position
  function automatic logic [BOUND_W-1:0] weight(input logic [POS_W-1:0] i);
    logic [BOUND_W-1:0] w, pv;
    w = '0;
    pv = BOUND_W'(1);
    for (int k = 0; k < DIGITS; k++) begin
      if (i == POS_W'(k)) w = pv;
      pv = BOUND_W'(pv * BOUND_W'(10));
    end
    return w;
  endfunction

  // per-position term for one bound
  function automatic logic [OCC_W-1:0] term(input logic [3:0] cur,
      input logic [BOUND_W-1:0] pre, input logic [BOUND_W-1:0] suf,
      input logic [BOUND_W-1:0] p, input logic [POS_W-1:0] len,
      input logic [POS_W-1:0] i, input logic [DIGIT_W-1:0] d);
    logic [OCC_W-1:0] r;
    r = '0;
    if ((i < len) && !(d == '0 && i == len - 1'b1)) begin
      if (i < len - 1'b1) begin
        r = OCC_W'(pre * p);
        if (d == '0) r = r - OCC_W'(p);
      end
      if (cur == d) r = r + OCC_W'(suf) + OCC_W'(1);
      else if (cur > d) r = r + OCC_W'(p);
    end
    return r;
  endfunction

  // positions walk from the most significant down
  logic [POS_W-1:0]   idx;
  logic [BOUND_W-1:0] p_w;
  logic [3:0]         hi_cur, lo_cur;
  logic [BOUND_W-1:0] hi_suf, lo_suf;
  logic [OCC_W-1:0]   t_hi, t_lo;
  always_comb begin
    idx = POS_W'(DIGITS - 1) - pos;
    p_w = weight(idx);
    hi_cur = hi_bcd[4*idx +: 4];
    lo_cur = lo_bcd[4*idx +: 4];
    hi_suf = hi_rem - BOUND_W'(hi_cur * p_w);
    lo_suf = lo_rem - BOUND_W'(lo_cur * p_w);
    t_hi = term(hi_cur, hi_pre, hi_suf, p_w, hi_len, idx, dsel);
    t_lo = term(lo_cur, lo_pre, lo_suf, p_w, lo_len, idx, dsel);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (a > b) begin
        hi_bin <= a;
        lo_bin <= b - 1'b1;
        hi_val <= a;
        lo_val <= b - 1'b1;
      end else begin
        hi_bin <= b;
        lo_bin <= a - 1'b1;
        hi_val <= b;
        lo_val <= a - 1'b1;
      end
      conv_cnt <= '0;
      hi_len <= '0;
      lo_len <= '0;
      dsel <= '0;
    end
    if (cmd.conv_step) begin
      hi_bcd <= {hr, hi_bcd[BCD_W-1:4]};
      lo_bcd <= {lr, lo_bcd[BCD_W-1:4]};
      hi_bin <= hq;
      lo_bin <= lq;
      if (hi_bin != '0) hi_len <= conv_cnt + 1'b1;
      if (lo_bin != '0) lo_len <= conv_cnt + 1'b1;
      conv_cnt <= conv_cnt + 1'b1;
    end
    if (cmd.start_digit) begin
      pos <= '0;
      acc <= '0;
      hi_pre <= '0;
      lo_pre <= '0;
      hi_rem <= hi_val;
      lo_rem <= lo_val;
    end
    if (cmd.count_hi) begin
      acc <= acc + t_hi - t_lo;
      pos <= pos + 1'b1;
      hi_pre <= BOUND_W'(hi_pre * BOUND_W'(10)) + BOUND_W'(hi_cur);
      lo_pre <= BOUND_W'(lo_pre * BOUND_W'(10)) + BOUND_W'(lo_cur);
      hi_rem <= hi_suf;
      lo_rem <= lo_suf;
    end
    if (cmd.next_digit) dsel <= dsel + 1'b1;
  end

  assign stat.conv_done = (conv_cnt == POS_W'(DIGITS - 1));
  assign stat.pos_done = (pos == POS_W'(DIGITS - 1));
  assign stat.last_digit = (dsel == LAST_DIGIT);
  assign digit = dsel;
  assign occurrences = acc;

endmodule

// ===== rtl/rdoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdoc_ctrl
// sequencer for conversion, per-digit counting and result transfer
// ----------------------------------------------------------------------------
module rdoc_ctrl import rdoc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CONV;
      ST_CONV: if (stat.conv_done) state_next = ST_HI;
      ST_HI:   if (stat.pos_done) state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = stat.last_digit ? ST_IDLE : ST_HI;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_last = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        cmd.start_digit = stat.conv_done;
      end
      ST_HI: cmd.count_hi = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        out_last = stat.last_digit;
        cmd.next_digit = out_ready;
        cmd.start_digit = out_ready;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/range_digit_occurrence_counter_unit.sv =====
// ----------------------------------------------------------------------------
// range_digit_occurrence_counter_unit
// counts occurrences of each decimal digit over an integer range
// ----------------------------------------------------------------------------
// One query of two bounds is taken, clamped to 1..10^DIGITS-1 and ordered,
// then ten results stream out, digit 0 to 9, the last with tlast. A query
// takes bcd conversion of all DIGITS positions, then positional counting
// over all DIGITS positions per digit and one output state held until
// m_tready; a new query is taken only after the last result is accepted.
module range_digit_occurrence_counter_unit import rdoc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // bound_one[26:0], bound_two[53:27]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // digit[3:0], occurrences[30:4]
  output logic        m_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [DIGIT_W-1:0] digit;
  logic [OCC_W-1:0]   occurrences;

  rdoc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
    .stat(stat), .cmd(cmd)
  );

  rdoc_datapath u_dp (
    .clk(clk), .bound_one(s_tdata[26:0]), .bound_two(s_tdata[53:27]),
    .cmd(cmd), .stat(stat), .digit(digit), .occurrences(occurrences)
  );

  assign m_tdata = {1'b0, occurrences, digit};

endmodule
